// ----- hdl/nmds_pkg.sv -----
// Shared types and constants for the nearest display mode selector.
`timescale 1ns / 1ps
package nmds_pkg;

    localparam int MAX_MODES = 64;
    localparam int POS_W     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

    localparam int DIM_W     = 16;
    localparam int RATE_W    = 12;
    localparam int INDEX_W   = 6;
    localparam int SCORE_W   = 34;
    localparam int SQ_W      = 2 * DIM_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_REFRESH = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef struct packed {
        logic [DIM_W-1:0]  aim_width;
        logic [DIM_W-1:0]  aim_height;
        logic [RATE_W-1:0] aim_refresh;
    } cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [RATE_W-1:0] refresh;
        logic              interlaced;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [RATE_W-1:0]  refresh;
        logic               interlaced;
        logic               last;
        logic [SCORE_W-1:0] score;
    } scored_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [RATE_W-1:0]  refresh;
        logic [SCORE_W-1:0] score;
    } result_t;

endpackage

// ----- hdl/nearest_display_mode_select_top.sv -----
// Top level of the nearest display mode selector: APB targets, mode stream in, winner out.
// Throughput: one mode per clock; a waiting result stalls the stream only when the next
// last mode reaches the best-fit stage before the result is taken.
// The winner shows on m_tvalid once the last mode has passed the input, score and result registers.
// Reset (rst_n, async, low): clears targets, running best, position count and valids.
`timescale 1ns / 1ps
module nearest_display_mode_select_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nmds_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nmds_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nmds_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // mode stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // mode_width, mode_height, mode_refresh, zero pad
    input  logic                               s_tuser,  // is_interlaced
    input  logic                               s_tlast,  // last_mode
    // winner out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [87:0]                        m_tdata,  // best_index, best_width, best_height,
                                                         // best_refresh, fit score, zero pad
    output logic                               m_tuser   // found
);

    nmds_pkg::cfg_t       cfg;
    nmds_pkg::item_t      in_item;
    nmds_pkg::scored_t    sc_item;
    nmds_pkg::result_t    res;
    logic                 sc_valid;
    logic                 sc_advance;

    // Register file; the user must change targets only while the stream is idle; the block does not enforce this.
    nmds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the inbound transaction.
    assign in_item.width      = s_tdata[15:0];
    assign in_item.height     = s_tdata[31:16];
    assign in_item.refresh    = s_tdata[43:32];
    assign in_item.interlaced = s_tuser;
    assign in_item.last       = s_tlast;

    // Input register, then the score register.
    nmds_score u_score (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .sc_valid   (sc_valid),
        .sc_advance (sc_advance),
        .sc_item    (sc_item)
    );

    // Compare against the running best; emit and clear on the last mode.
    nmds_best u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .sc_valid   (sc_valid),
        .sc_advance (sc_advance),
        .sc_item    (sc_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // Pack the outbound transaction, lowest field first.
    assign m_tdata = {4'b0, res.score, res.refresh, res.height, res.width, res.index};
    assign m_tuser = res.found;

endmodule

// ----- hdl/nmds_cfg.sv -----
// APB register file holding the target width, height and refresh.
`timescale 1ns / 1ps
module nmds_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nmds_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nmds_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nmds_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output nmds_pkg::cfg_t                     cfg
);

    nmds_pkg::cfg_t                   cfg_reg;
    nmds_pkg::cfg_t                   cfg_next;
    logic [nmds_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[nmds_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                nmds_pkg::REG_TARGET_WIDTH:
                    cfg_next.aim_width = pwdata[nmds_pkg::DIM_W-1:0];
                nmds_pkg::REG_TARGET_HEIGHT:
                    cfg_next.aim_height = pwdata[nmds_pkg::DIM_W-1:0];
                nmds_pkg::REG_TARGET_REFRESH:
                    cfg_next.aim_refresh = pwdata[nmds_pkg::RATE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            nmds_pkg::REG_TARGET_WIDTH:
                prdata = nmds_pkg::APB_DATA_W'(cfg_reg.aim_width);
            nmds_pkg::REG_TARGET_HEIGHT:
                prdata = nmds_pkg::APB_DATA_W'(cfg_reg.aim_height);
            nmds_pkg::REG_TARGET_REFRESH:
                prdata = nmds_pkg::APB_DATA_W'(cfg_reg.aim_refresh);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/nmds_score.sv -----
// Input register and score stage: squared size errors plus weighted refresh error (only if target refresh is nonzero).
`timescale 1ns / 1ps
module nmds_score (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nmds_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nmds_pkg::item_t      in_item,
    output logic                 sc_valid,
    input  logic                 sc_advance,
    output nmds_pkg::scored_t    sc_item
);

    logic                                a_valid_reg;
    logic                                a_valid_next;
    nmds_pkg::item_t                     a_item_reg;
    logic                                b_valid_reg;
    logic                                b_valid_next;
    nmds_pkg::scored_t                   b_item_reg;
    nmds_pkg::scored_t                   b_item_next;
    logic                                b_take;
    logic                                a_load;
    logic [nmds_pkg::DIM_W-1:0]          dw;
    logic [nmds_pkg::DIM_W-1:0]          dh;
    logic [nmds_pkg::RATE_W-1:0]         dr;
    logic [nmds_pkg::SQ_W-1:0]           dw_sq;
    logic [nmds_pkg::SQ_W-1:0]           dh_sq;
    logic [nmds_pkg::RATE_W+6:0]         dr_x100;
    logic [nmds_pkg::SCORE_W-1:0]        score;

    // Stage B takes a new item when empty or when the best stage consumes it.
    assign b_take   = !b_valid_reg || sc_advance;
    assign in_ready = !a_valid_reg || b_take;
    assign a_load   = in_valid && in_ready;

    assign a_valid_next = a_load ? 1'b1 : (b_take ? 1'b0 : a_valid_reg);
    assign b_valid_next = b_take ? a_valid_reg : b_valid_reg;

    always_comb
    begin
        dw = (a_item_reg.width > cfg.aim_width) ?
             a_item_reg.width - cfg.aim_width : cfg.aim_width - a_item_reg.width;
        dh = (a_item_reg.height > cfg.aim_height) ?
             a_item_reg.height - cfg.aim_height : cfg.aim_height - a_item_reg.height;
        dr = (a_item_reg.refresh > cfg.aim_refresh) ?
             a_item_reg.refresh - cfg.aim_refresh :
             cfg.aim_refresh - a_item_reg.refresh;
        dw_sq = nmds_pkg::SQ_W'(dw) * nmds_pkg::SQ_W'(dw);
        dh_sq = nmds_pkg::SQ_W'(dh) * nmds_pkg::SQ_W'(dh);
        // 100 = 64 + 32 + 4
        dr_x100 = ({1'b0, dr, 6'b0} + {2'b0, dr, 5'b0}) + {5'b0, dr, 2'b0};
        score = nmds_pkg::SCORE_W'(dw_sq) + nmds_pkg::SCORE_W'(dh_sq);
        if (cfg.aim_refresh != '0)
        begin
            score = score + nmds_pkg::SCORE_W'(dr_x100);
        end
        b_item_next.width      = a_item_reg.width;
        b_item_next.height     = a_item_reg.height;
        b_item_next.refresh    = a_item_reg.refresh;
        b_item_next.interlaced = a_item_reg.interlaced;
        b_item_next.last       = a_item_reg.last;
        b_item_next.score      = score;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_item_reg <= in_item;
        end
        if (b_take)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign sc_valid = b_valid_reg;
    assign sc_item  = b_item_reg;

endmodule

// ----- hdl/nmds_best.sv -----
// Running best-fit tracker and result register.
`timescale 1ns / 1ps
module nmds_best (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sc_valid,
    output logic                 sc_advance,
    input  nmds_pkg::scored_t    sc_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output nmds_pkg::result_t    res
);

    logic                                have_best_reg;
    logic [nmds_pkg::SCORE_W-1:0]        lowest_score_reg;
    logic [nmds_pkg::INDEX_W-1:0]        chosen_index_reg;
    logic [nmds_pkg::DIM_W-1:0]          chosen_width_reg;
    logic [nmds_pkg::DIM_W-1:0]          chosen_height_reg;
    logic [nmds_pkg::RATE_W-1:0]         chosen_refresh_reg;
    logic [nmds_pkg::POS_W-1:0]          pos_reg;
    logic [nmds_pkg::POS_W-1:0]          pos_next;
    logic                                better;
    logic                                fire;
    logic                                out_valid_reg;
    nmds_pkg::result_t                   out_reg;
    nmds_pkg::result_t                   out_next;
    logic                                have_upd;
    logic [nmds_pkg::SCORE_W-1:0]        score_upd;
    logic [nmds_pkg::INDEX_W-1:0]        index_upd;
    logic [nmds_pkg::DIM_W-1:0]          width_upd;
    logic [nmds_pkg::DIM_W-1:0]          height_upd;
    logic [nmds_pkg::RATE_W-1:0]         refresh_upd;

    // Hold a last item while the result register is full and not draining.
    assign fire = sc_valid && (!sc_item.last || !out_valid_reg || res_ready);
    assign sc_advance = !sc_valid || fire;

    assign better = !sc_item.interlaced &&
                    ((sc_item.score < lowest_score_reg) ||
                     ((sc_item.score == lowest_score_reg) && have_best_reg &&
                      (sc_item.refresh > chosen_refresh_reg)));

    assign pos_next = (pos_reg == nmds_pkg::POS_W'(nmds_pkg::MAX_MODES - 1)) ?
                      '0 : pos_reg + 1'b1;

    always_comb
    begin
        have_upd    = better ? 1'b1 : have_best_reg;
        score_upd   = better ? sc_item.score : lowest_score_reg;
        index_upd   = better ? nmds_pkg::INDEX_W'(pos_reg) : chosen_index_reg;
        width_upd   = better ? sc_item.width : chosen_width_reg;
        height_upd  = better ? sc_item.height : chosen_height_reg;
        refresh_upd = better ? sc_item.refresh : chosen_refresh_reg;
        out_next    = '0;
        if (have_upd)
        begin
            out_next.found   = 1'b1;
            out_next.index   = index_upd;
            out_next.width   = width_upd;
            out_next.height  = height_upd;
            out_next.refresh = refresh_upd;
            out_next.score   = score_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg      <= 1'b0;
            lowest_score_reg   <= nmds_pkg::SCORE_MAX;
            chosen_index_reg   <= '0;
            chosen_width_reg   <= '0;
            chosen_height_reg  <= '0;
            chosen_refresh_reg <= '0;
            pos_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (fire && sc_item.last)
            begin
                have_best_reg      <= 1'b0;
                lowest_score_reg   <= nmds_pkg::SCORE_MAX;
                chosen_index_reg   <= '0;
                chosen_width_reg   <= '0;
                chosen_height_reg  <= '0;
                chosen_refresh_reg <= '0;
                pos_reg            <= '0;
            end
            else if (fire)
            begin
                have_best_reg      <= have_upd;
                lowest_score_reg   <= score_upd;
                chosen_index_reg   <= index_upd;
                chosen_width_reg   <= width_upd;
                chosen_height_reg  <= height_upd;
                chosen_refresh_reg <= refresh_upd;
                pos_reg            <= pos_next;
            end
            if (fire && sc_item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && sc_item.last)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef SYNTHESIS
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && sc_item.last) |=> (!have_best_reg && pos_reg == '0))
        else $error("best-fit state not cleared after a result");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg.score == '0 && out_reg.index == '0))
        else $error("empty result carries nonzero fields");

    a_best_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        have_best_reg |-> (lowest_score_reg != nmds_pkg::SCORE_MAX))
        else $error("held best score equals the empty marker");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |-> !(fire && sc_item.last))
        else $error("pending result overwritten");
`endif

endmodule
